// ===== hw/rtl/asd_pkg.sv =====
// Shared types, constants and register codes of the accelerometer step detector.
`default_nettype none

package asd_pkg;

	localparam int AXES = 3;
	localparam int SAMPLE_W = 16;
	localparam int GAP_W = 10;
	localparam int CFG_DATA_W = 15;
	localparam int CFG_INDEX_W = 2;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
	localparam logic [GAP_W-1:0] GAP_LIMIT = 10'd1023;

	// Register indexes of the configuration port.
	localparam logic [CFG_INDEX_W-1:0] REG_PRECISION = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_INTERVAL_MIN = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_INTERVAL_MAX = 2'd3;

	// Register values after reset.
	localparam logic [14:0] RST_PRECISION = 15'd8;
	localparam logic [9:0] RST_WINDOW_LENGTH = 10'd50;
	localparam logic [9:0] RST_INTERVAL_MIN = 10'd10;
	localparam logic [9:0] RST_INTERVAL_MAX = 10'd100;

	// Codes of the busy axis.
	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	localparam int DEFAULT_AVERAGE_DEPTH = 4;
	// Depth of the internal queues; must be a power of two.
	localparam int QUEUE_DEPTH = 4;

	typedef logic [AXES-1:0][SAMPLE_W-1:0] trio_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] accel_x;
		logic signed [SAMPLE_W-1:0] accel_y;
		logic signed [SAMPLE_W-1:0] accel_z;
	} in_item_t;

	typedef struct packed {
		logic                       step_found;
		logic                       crossing_seen;
		logic [1:0]                 busy_axis;
		logic signed [SAMPLE_W-1:0] smooth_x;
		logic signed [SAMPLE_W-1:0] smooth_y;
		logic signed [SAMPLE_W-1:0] smooth_z;
	} out_item_t;

	typedef struct packed {
		logic [14:0] precision;
		logic [9:0]  window_length;
		logic [9:0]  interval_min;
		logic [9:0]  interval_max;
	} cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/asd_fifo.sv =====
// Small first-in first-out queue with a fill level output.
`default_nettype none

module asd_fifo #(
	parameter int WIDTH = 48,
	parameter int DEPTH = asd_pkg::QUEUE_DEPTH,
	localparam int PTR_W = $clog2(DEPTH),
	localparam int LVL_W = $clog2(DEPTH + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             rd,
	output logic      [WIDTH-1:0] rdata,
	output logic                  empty,
	output logic      [LVL_W-1:0] level
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [LVL_W-1:0] level_q;
	logic             do_rd;

	assign empty = (level_q == '0);
	assign do_rd = rd & ~empty;
	assign rdata = mem_q[rptr_q];
	assign level = level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			level_q <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (wr && !do_rd) begin
				level_q <= level_q + 1'b1;
			end else if (!wr && do_rd) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/asd_front.sv =====
// Front end: sample ring, running sum and divide-by-depth averaging pipeline.
`default_nettype none

module asd_front #(
	parameter int AVG_DEPTH = asd_pkg::DEFAULT_AVERAGE_DEPTH,
	parameter int QDEPTH = asd_pkg::QUEUE_DEPTH,
	localparam int LVL_W = $clog2(QDEPTH + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire asd_pkg::in_item_t sample,
	input  wire logic [LVL_W-1:0]  q_level,
	output logic                   full,
	output logic                   q_wr,
	output asd_pkg::trio_t         q_data
);

	localparam int PTR_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
	localparam int SUM_W = asd_pkg::SAMPLE_W + $clog2(AVG_DEPTH);
	localparam int MAG_W = SUM_W;
	// The reciprocal is exact for every magnitude below 2**MAG_W with this shift.
	localparam int REC_SH = MAG_W + 5;
	localparam longint RECIP_L = ((longint'(1) << REC_SH) + AVG_DEPTH - 1) / AVG_DEPTH;
	localparam logic [REC_SH:0] RECIP = RECIP_L[REC_SH:0];
	localparam int PROD_W = MAG_W + REC_SH + 1;
	localparam int OCC_W = LVL_W + 1;

	logic signed [asd_pkg::SAMPLE_W-1:0] din [asd_pkg::AXES];
	logic signed [asd_pkg::SAMPLE_W-1:0] ring_q [AVG_DEPTH][asd_pkg::AXES];
	logic [PTR_W-1:0]                    ptr_q;
	logic [PTR_W-1:0]                    ptr_next;
	logic signed [SUM_W-1:0]             sum_q [asd_pkg::AXES];
	logic signed [SUM_W-1:0]             sum_next [asd_pkg::AXES];
	logic [MAG_W-1:0]                    mag [asd_pkg::AXES];
	logic [PROD_W-1:0]                   prod_s2 [asd_pkg::AXES];
	logic                                neg_s2 [asd_pkg::AXES];
	logic [asd_pkg::SAMPLE_W-1:0]        quot [asd_pkg::AXES];
	logic                                valid_s1;
	logic                                valid_s2;
	logic                                accept;
	logic [OCC_W-1:0]                    occupancy;

	assign din[0] = sample.accel_x;
	assign din[1] = sample.accel_y;
	assign din[2] = sample.accel_z;

	// Items in flight count against the queue so it can never overflow.
	assign occupancy = OCC_W'(q_level) + OCC_W'(valid_s1) + OCC_W'(valid_s2);
	assign full = (occupancy >= OCC_W'(QDEPTH));
	assign accept = push & ~full;

	assign ptr_next = (ptr_q == PTR_W'(AVG_DEPTH - 1)) ? '0 : ptr_q + 1'b1;

	always_comb begin
		for (int a = 0; a < asd_pkg::AXES; a++) begin
			sum_next[a] = sum_q[a] - SUM_W'(ring_q[ptr_q][a]) + SUM_W'(din[a]);
			mag[a] = sum_q[a][SUM_W-1] ? MAG_W'(-sum_q[a]) : MAG_W'(sum_q[a]);
			quot[a] = prod_s2[a][REC_SH +: asd_pkg::SAMPLE_W];
			q_data[a] = neg_s2[a] ? -quot[a] : quot[a];
		end
	end

	assign q_wr = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AVG_DEPTH; i++) begin
				for (int a = 0; a < asd_pkg::AXES; a++) begin
					ring_q[i][a] <= '0;
				end
			end
			for (int a = 0; a < asd_pkg::AXES; a++) begin
				sum_q[a] <= '0;
			end
			ptr_q    <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			if (accept) begin
				for (int a = 0; a < asd_pkg::AXES; a++) begin
					ring_q[ptr_q][a] <= din[a];
					sum_q[a]         <= sum_next[a];
				end
				ptr_q <= ptr_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			for (int a = 0; a < asd_pkg::AXES; a++) begin
				prod_s2[a] <= mag[a] * RECIP;
				neg_s2[a]  <= sum_q[a][SUM_W-1];
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/asd_back.sv =====
// Back end: window tracker, precision shift register, busy axis and step judge.
`default_nettype none

module asd_back #(
	parameter int QDEPTH = asd_pkg::QUEUE_DEPTH,
	localparam int LVL_W = $clog2(QDEPTH + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire asd_pkg::cfg_t    cfg,
	input  wire asd_pkg::trio_t   head,
	input  wire logic             head_valid,
	output logic                  pull,
	input  wire logic [LVL_W-1:0] out_level,
	output logic                  out_wr,
	output asd_pkg::out_item_t    out_item
);

	localparam int OCC_W = LVL_W + 1;
	localparam int SW = asd_pkg::SAMPLE_W;

	// Architectural state.
	logic [9:0]          wcount_q;
	logic signed [SW-1:0] cur_max_q [asd_pkg::AXES];
	logic signed [SW-1:0] cur_min_q [asd_pkg::AXES];
	logic signed [SW-1:0] prev_max_q [asd_pkg::AXES];
	logic signed [SW-1:0] prev_min_q [asd_pkg::AXES];
	logic signed [SW-1:0] older_q [asd_pkg::AXES];
	logic signed [SW-1:0] newer_q [asd_pkg::AXES];
	logic [asd_pkg::GAP_W-1:0] gap_q;

	// First stage: window and shift register update.
	logic                 close_win;
	logic signed [SW-1:0] smooth [asd_pkg::AXES];
	logic signed [SW-1:0] base_max [asd_pkg::AXES];
	logic signed [SW-1:0] base_min [asd_pkg::AXES];
	logic signed [SW-1:0] nmax [asd_pkg::AXES];
	logic signed [SW-1:0] nmin [asd_pkg::AXES];
	logic signed [SW:0]   dshift [asd_pkg::AXES];
	logic [SW:0]          adshift [asd_pkg::AXES];
	logic signed [SW-1:0] nnew [asd_pkg::AXES];
	logic [OCC_W-1:0]     occupancy;

	logic                 valid_s1;
	logic signed [SW-1:0] max_s1 [asd_pkg::AXES];
	logic signed [SW-1:0] min_s1 [asd_pkg::AXES];
	logic signed [SW-1:0] pmax_s1 [asd_pkg::AXES];
	logic signed [SW-1:0] pmin_s1 [asd_pkg::AXES];
	logic signed [SW-1:0] older_s1 [asd_pkg::AXES];
	logic signed [SW-1:0] newer_s1 [asd_pkg::AXES];
	logic signed [SW-1:0] smooth_s1 [asd_pkg::AXES];

	// Second stage: busy axis and threshold.
	logic signed [SW:0]   drange [asd_pkg::AXES];
	logic [SW:0]          range [asd_pkg::AXES];
	logic [1:0]           axis;
	logic signed [SW-1:0] sel_pmax;
	logic signed [SW-1:0] sel_pmin;
	logic signed [SW-1:0] sel_older;
	logic signed [SW-1:0] sel_newer;
	logic signed [SW:0]   mid_sum;
	logic signed [SW:0]   mid_adj;

	logic                 valid_s2;
	logic [1:0]           axis_s2;
	logic signed [SW-1:0] th_s2;
	logic signed [SW-1:0] older_s2;
	logic signed [SW-1:0] newer_s2;
	logic signed [SW-1:0] smooth_s2 [asd_pkg::AXES];

	// Third stage: crossing and gap judge.
	logic                      crossing;
	logic                      step;
	logic [asd_pkg::GAP_W-1:0] gap_inc;

	assign occupancy = OCC_W'(out_level) + OCC_W'(valid_s1) + OCC_W'(valid_s2);
	assign pull = head_valid && (occupancy < OCC_W'(QDEPTH));
	assign close_win = (wcount_q >= cfg.window_length);

	always_comb begin
		for (int a = 0; a < asd_pkg::AXES; a++) begin
			smooth[a]   = $signed(head[a]);
			base_max[a] = close_win ? asd_pkg::SAMPLE_MIN : cur_max_q[a];
			base_min[a] = close_win ? asd_pkg::SAMPLE_MAX : cur_min_q[a];
			nmax[a]     = (smooth[a] > base_max[a]) ? smooth[a] : base_max[a];
			nmin[a]     = (smooth[a] < base_min[a]) ? smooth[a] : base_min[a];
			dshift[a]   = (SW+1)'(smooth[a]) - (SW+1)'(newer_q[a]);
			adshift[a]  = dshift[a][SW] ? (SW+1)'(-dshift[a]) : (SW+1)'(dshift[a]);
			nnew[a]     = (adshift[a] > (SW+1)'(cfg.precision)) ? smooth[a] : newer_q[a];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcount_q <= '0;
			for (int a = 0; a < asd_pkg::AXES; a++) begin
				cur_max_q[a]  <= asd_pkg::SAMPLE_MIN;
				cur_min_q[a]  <= asd_pkg::SAMPLE_MAX;
				prev_max_q[a] <= '0;
				prev_min_q[a] <= '0;
				older_q[a]    <= '0;
				newer_q[a]    <= '0;
			end
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			gap_q    <= '0;
		end else begin
			valid_s1 <= pull;
			valid_s2 <= valid_s1;
			if (pull) begin
				wcount_q <= close_win ? 10'd1 : wcount_q + 1'b1;
				for (int a = 0; a < asd_pkg::AXES; a++) begin
					if (close_win) begin
						prev_max_q[a] <= cur_max_q[a];
						prev_min_q[a] <= cur_min_q[a];
					end
					cur_max_q[a] <= nmax[a];
					cur_min_q[a] <= nmin[a];
					older_q[a]   <= newer_q[a];
					newer_q[a]   <= nnew[a];
				end
			end
			if (valid_s2) begin
				gap_q <= crossing ? '0 : gap_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pull) begin
			for (int a = 0; a < asd_pkg::AXES; a++) begin
				max_s1[a]    <= nmax[a];
				min_s1[a]    <= nmin[a];
				pmax_s1[a]   <= close_win ? cur_max_q[a] : prev_max_q[a];
				pmin_s1[a]   <= close_win ? cur_min_q[a] : prev_min_q[a];
				older_s1[a]  <= newer_q[a];
				newer_s1[a]  <= nnew[a];
				smooth_s1[a] <= smooth[a];
			end
		end
	end

	always_comb begin
		for (int a = 0; a < asd_pkg::AXES; a++) begin
			drange[a] = (SW+1)'(max_s1[a]) - (SW+1)'(min_s1[a]);
			range[a]  = drange[a][SW] ? (SW+1)'(-drange[a]) : (SW+1)'(drange[a]);
		end
		// Ties go to x, then y.
		if (range[0] >= range[1] && range[0] >= range[2]) begin
			axis = asd_pkg::AXIS_X;
		end else if (range[1] >= range[2]) begin
			axis = asd_pkg::AXIS_Y;
		end else begin
			axis = asd_pkg::AXIS_Z;
		end
		unique case (axis)
			asd_pkg::AXIS_Y: begin
				sel_pmax  = pmax_s1[1];
				sel_pmin  = pmin_s1[1];
				sel_older = older_s1[1];
				sel_newer = newer_s1[1];
			end
			asd_pkg::AXIS_Z: begin
				sel_pmax  = pmax_s1[2];
				sel_pmin  = pmin_s1[2];
				sel_older = older_s1[2];
				sel_newer = newer_s1[2];
			end
			default: begin
				sel_pmax  = pmax_s1[0];
				sel_pmin  = pmin_s1[0];
				sel_older = older_s1[0];
				sel_newer = newer_s1[0];
			end
		endcase
		// Midpoint halved with truncation toward zero.
		mid_sum = (SW+1)'(sel_pmax) + (SW+1)'(sel_pmin);
		mid_adj = mid_sum + (SW+1)'(mid_sum[SW]);
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			axis_s2  <= axis;
			th_s2    <= mid_adj[SW:1];
			older_s2 <= sel_older;
			newer_s2 <= sel_newer;
			for (int a = 0; a < asd_pkg::AXES; a++) begin
				smooth_s2[a] <= smooth_s1[a];
			end
		end
	end

	assign crossing = (older_s2 > th_s2) && (newer_s2 < th_s2);
	assign gap_inc = (gap_q < asd_pkg::GAP_LIMIT) ? gap_q + 1'b1 : gap_q;
	assign step = crossing && (gap_inc > cfg.interval_min) && (gap_inc < cfg.interval_max);

	assign out_wr = valid_s2;
	assign out_item.step_found = step;
	assign out_item.crossing_seen = crossing;
	assign out_item.busy_axis = axis_s2;
	assign out_item.smooth_x = smooth_s2[0];
	assign out_item.smooth_y = smooth_s2[1];
	assign out_item.smooth_z = smooth_s2[2];

endmodule

`default_nettype wire

// ===== hw/rtl/accel_step_detector.sv =====
// Top level of the three-axis accelerometer step detector.
`default_nettype none

// The block takes one signed three-axis sample per item on the input queue
// port (push, full, sample) and returns exactly one result item per sample on
// the output queue port (empty, pop, result), in order. Each result carries the
// moving average of the last AVERAGE_DEPTH samples, the busy axis, whether the
// shift register on that axis fell through the previous window's midpoint, and
// whether that crossing counts as a step under the interval window.
// A sample pushed at the input passes through the averaging (running sum,
// then multiply by the reciprocal of the depth), a four-entry queue, the
// window and axis tracking, and a four-entry result queue before it shows
// up as a result on the output port.
// The block takes one item every cycle while full is low; the fixed multiply
// in the front end and the three-stage back end both run at that rate.
// When the receiver stops popping, the result queue fills, the back end stops
// drawing from the middle queue, and full rises once that queue and the items
// still in the front pipeline account for all its slots.
// Reset clears the sample ring, running sums, window state, shift register,
// gap counter and both queues, and loads the configuration registers with
// their defaults. Registers are written through cfg_we, cfg_index and
// cfg_data; the user must do so only while no item is in flight (not enforced).

module accel_step_detector #(
	parameter int AVERAGE_DEPTH = asd_pkg::DEFAULT_AVERAGE_DEPTH
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               push,
	input  wire asd_pkg::in_item_t                  sample,
	output logic                                    full,
	output asd_pkg::out_item_t                      result,
	output logic                                    empty,
	input  wire logic                               pop,
	input  wire logic                               cfg_we,
	input  wire logic [asd_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [asd_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int QDEPTH = asd_pkg::QUEUE_DEPTH;
	localparam int LVL_W = $clog2(QDEPTH + 1);

	asd_pkg::cfg_t      cfg_q;
	logic               mid_wr;
	asd_pkg::trio_t     mid_wdata;
	asd_pkg::trio_t     mid_rdata;
	logic               mid_empty;
	logic               mid_rd;
	logic [LVL_W-1:0]   mid_level;
	logic               out_wr;
	asd_pkg::out_item_t out_wdata;
	logic [LVL_W-1:0]   out_level;

	// Configuration registers: written directly, no handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.precision     <= asd_pkg::RST_PRECISION;
			cfg_q.window_length <= asd_pkg::RST_WINDOW_LENGTH;
			cfg_q.interval_min  <= asd_pkg::RST_INTERVAL_MIN;
			cfg_q.interval_max  <= asd_pkg::RST_INTERVAL_MAX;
		end else if (cfg_we) begin
			unique case (cfg_index)
				asd_pkg::REG_PRECISION:     cfg_q.precision     <= cfg_data;
				asd_pkg::REG_WINDOW_LENGTH: cfg_q.window_length <= cfg_data[9:0];
				asd_pkg::REG_INTERVAL_MIN:  cfg_q.interval_min  <= cfg_data[9:0];
				asd_pkg::REG_INTERVAL_MAX:  cfg_q.interval_max  <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// Front end: averaging of the incoming samples.
	asd_front #(
		.AVG_DEPTH (AVERAGE_DEPTH),
		.QDEPTH    (QDEPTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.sample  (sample),
		.q_level (mid_level),
		.full    (full),
		.q_wr    (mid_wr),
		.q_data  (mid_wdata)
	);

	// Queue of smoothed samples between the two halves.
	asd_fifo #(
		.WIDTH ($bits(asd_pkg::trio_t)),
		.DEPTH (QDEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (mid_wr),
		.wdata  (mid_wdata),
		.rd     (mid_rd),
		.rdata  (mid_rdata),
		.empty  (mid_empty),
		.level  (mid_level)
	);

	// Back end: peak windows, shift register and step decision.
	asd_back #(
		.QDEPTH (QDEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head       (mid_rdata),
		.head_valid (~mid_empty),
		.pull       (mid_rd),
		.out_level  (out_level),
		.out_wr     (out_wr),
		.out_item   (out_wdata)
	);

	// Result queue; its head is the result port.
	asd_fifo #(
		.WIDTH ($bits(asd_pkg::out_item_t)),
		.DEPTH (QDEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (out_wr),
		.wdata  (out_wdata),
		.rd     (pop),
		.rdata  (result),
		.empty  (empty),
		.level  (out_level)
	);

`ifndef SYNTH
	// The front end's credit check must keep the middle queue from overflowing.
	a_mid_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		mid_wr |-> (mid_level < LVL_W'(QDEPTH)))
		else $error("middle queue written while full");

	// The back end's credit check must keep the result queue from overflowing.
	a_out_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_wr |-> (out_level < LVL_W'(QDEPTH)))
		else $error("result queue written while full");

	// A step can only be reported on a sample that also crossed the threshold.
	a_step_needs_crossing: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.step_found) |-> result.crossing_seen)
		else $error("step reported without a crossing");

	// The back end only draws an item that the middle queue actually holds.
	a_pull_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		mid_rd |-> (mid_level != '0))
		else $error("back end pulled from an empty queue");
`endif

endmodule

`default_nettype wire
